[design/sit_pkg.sv]
// Shared types, codes and field widths for the sorted id table.
`default_nettype none

package sit_pkg;

    // Field widths of the stream payloads.
    localparam int OPCODE_W  = 2;
    localparam int KEY_W     = 18;
    localparam int HANDLE_W  = 5;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Outcome of the shared key comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

`default_nettype wire

[design/sit_cmp.sv]
// Shared key comparator used for every search step and match check.
`default_nettype none

module sit_cmp #(
    parameter int WIDTH = 18
) (
    input  wire logic [WIDTH-1:0] table_key,
    input  wire logic [WIDTH-1:0] search_key,
    output sit_pkg::cmp_res_t     res
);
    import sit_pkg::*;

    // Stored key against the key being searched for.
    assign res.lt = (table_key < search_key);
    assign res.eq = (table_key == search_key);

endmodule

`default_nettype wire

[design/sit_mem.sv]
// Single-port-write, single-port-read table memory with a registered read.
`default_nettype none

module sit_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 23,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/sorted_id_table.sv]
// Top level of the sorted id table: sequencer, result register and table memory.
//
//   Channel  Ports             Payload (lowest bit up)
//   input    s_tvalid/tready   s_tdata: opcode[1:0], key[19:2], handle[24:20]
//   result   m_tvalid/tready   m_tdata: status[1:0], found_handle[6:2],
//                                       position[12:7], entry_count[18:13]
//
// One transaction is worked at a time; s_tready is high only while the sequencer is idle.
// A search makes at most ceil(log2(n+1)) steps for n entries; an insert then moves each
// later entry up one place and a delete each later entry down, one read and one write per
// entry; a full-table insert skips the search. One read port and one comparator serve all.
// Reset clears the entry count and the control state; the memory itself is not cleared.
// A result waits in the output register while the next transaction is accepted; the
// sequencer holds in its last state while that register is still full.
`default_nettype none

module sorted_id_table #(
    parameter int MAX_ENTRIES = 32,
    parameter int KEY_BITS    = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // opcode[1:0], key[19:2], handle[24:20], zero fill above
    input  wire logic [sit_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[1:0], found_handle[6:2], position[12:7], entry_count[18:13], zero fill above
    output logic      [sit_pkg::M_DATA_W-1:0]  m_tdata
);
    import sit_pkg::*;

    localparam int AW      = $clog2(MAX_ENTRIES);
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_EXT = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
    localparam int ENT_W   = KEY_BITS + HANDLE_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SWAIT = 4'd2;
    localparam logic [3:0] S_MWAIT = 4'd3;
    localparam logic [3:0] S_UPRD  = 4'd4;
    localparam logic [3:0] S_UPWR  = 4'd5;
    localparam logic [3:0] S_DNRD  = 4'd6;
    localparam logic [3:0] S_DNWR  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]            state_reg,  state_next;
    logic [CW-1:0]         count_reg,  count_next;
    logic [CW-1:0]         lo_reg,     lo_next;
    logic [CW-1:0]         hi_reg,     hi_next;
    logic [CW-1:0]         mid_reg,    mid_next;
    logic [CW-1:0]         idx_reg,    idx_next;
    logic [OPCODE_W-1:0]   op_reg,     op_next;
    logic [KEY_BITS-1:0]   key_reg,    key_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [HANDLE_W-1:0]   fh_reg,     fh_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg,  m_data_next;

    // Input field unpacking; the key is cut to KEY_BITS.
    logic [OPCODE_W-1:0]   in_opcode;
    logic [KEY_EXT-1:0]    in_key_ext;
    logic [KEY_BITS-1:0]   in_key;
    logic [HANDLE_W-1:0]   in_handle;

    assign in_opcode  = s_tdata[OPCODE_W-1:0];
    assign in_key_ext = KEY_EXT'(s_tdata[OPCODE_W +: KEY_W]);
    assign in_key     = in_key_ext[KEY_BITS-1:0];
    assign in_handle  = s_tdata[OPCODE_W+KEY_W +: HANDLE_W];

    // Memory ports.
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [AW-1:0]     rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [HANDLE_W-1:0] rd_handle;

    assign rd_key    = rd_data[ENT_W-1:HANDLE_W];
    assign rd_handle = rd_data[HANDLE_W-1:0];

    sit_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared comparator between the entry just read and the search key.
    cmp_res_t cmp;

    sit_cmp #(
        .WIDTH (KEY_BITS)
    ) u_cmp (
        .table_key  (rd_key),
        .search_key (key_reg),
        .res        (cmp)
    );

    // Helper values for the search and shift steps.
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_val;
    logic [CW:0]   idx_inc;
    logic [CW-1:0] res_pos;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_val = mid_sum[CW:1];
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign res_pos = (status_reg == ST_OK) ? lo_reg : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        handle_next  = handle_reg;
        status_next  = status_reg;
        fh_next      = fh_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = rd_data;
        rd_addr      = '0;

        // The output register empties when its transaction is taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_opcode;
                    key_next    = in_key;
                    handle_next = in_handle;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    status_next = ST_OK;
                    fh_next     = '0;
                    case (in_opcode) inside
                        OP_INSERT: begin
                            if (count_reg >= CW'(MAX_ENTRIES)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next  = S_SRCH;
                            end
                        end
                        OP_DELETE, OP_LOOKUP: begin
                            state_next = S_SRCH;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // One binary search step: read the middle entry, or finish the search.
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    rd_addr    = mid_val[AW-1:0];
                    mid_next   = mid_val;
                    state_next = S_SWAIT;
                end else if (op_reg == OP_INSERT) begin
                    idx_next   = count_reg;
                    state_next = S_UPRD;
                end else if (lo_reg == count_reg) begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end else begin
                    rd_addr    = lo_reg[AW-1:0];
                    state_next = S_MWAIT;
                end
            end

            // Narrow the search range by the comparator outcome.
            S_SWAIT: begin
                if (cmp.lt) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end

            // Check the lower-bound entry for an exact match.
            S_MWAIT: begin
                if (!cmp.eq) begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end else if (op_reg == OP_LOOKUP) begin
                    fh_next    = rd_handle;
                    state_next = S_DONE;
                end else begin
                    idx_next   = lo_reg;
                    state_next = S_DNRD;
                end
            end

            // Insert: move entries up one place from the top, then store the new pair.
            S_UPRD: begin
                if (idx_reg > lo_reg) begin
                    rd_addr    = AW'(idx_reg - 1'b1);
                    state_next = S_UPWR;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg[AW-1:0];
                    wr_data    = {key_reg, handle_reg};
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_UPWR: begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - 1'b1;
                state_next = S_UPRD;
            end

            // Delete: move later entries down one place over the removed one.
            S_DNRD: begin
                if (idx_inc < {1'b0, count_reg}) begin
                    rd_addr    = idx_inc[AW-1:0];
                    state_next = S_DNWR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DNWR: begin
                wr_en      = 1'b1;
                idx_next   = idx_inc[CW-1:0];
                state_next = S_DNRD;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({POS_W'(count_reg), POS_W'(res_pos),
                                              fh_reg, status_reg});
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        handle_reg <= handle_next;
        status_reg <= status_next;
        fh_reg     <= fh_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

[design/sit_check.sv]
// Port-level assertions for the sorted id table and their bind to the top level.
`default_nettype none

module sit_check #(
    parameter int MAX_ENTRIES = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [sit_pkg::M_DATA_W-1:0]  m_tdata
);
    import sit_pkg::*;

    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_handle;
    logic [POS_W-1:0]    m_pos;
    logic [POS_W-1:0]    m_count;

    assign m_status = m_tdata[STATUS_W-1:0];
    assign m_handle = m_tdata[STATUS_W +: HANDLE_W];
    assign m_pos    = m_tdata[STATUS_W+HANDLE_W +: POS_W];
    assign m_count  = m_tdata[STATUS_W+HANDLE_W+POS_W +: POS_W];

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A failed operation reports no position and no handle.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status != ST_OK) |-> (m_pos == '0) && (m_handle == '0))
        else $error("failed operation carries position or handle");

    // A full table is reported only with the count at its limit.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == ST_FULL) |-> (m_count == POS_W'(MAX_ENTRIES)))
        else $error("table full reported below the limit");

    // A position never lies beyond the entry count.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (MAX_ENTRIES < 64) |-> (m_pos <= m_count))
        else $error("position beyond entry count");

endmodule

bind sorted_id_table sit_check #(.MAX_ENTRIES(MAX_ENTRIES)) u_sit_check (.*);

`default_nettype wire

[dv/tb_top.sv]
// Testbench for the sorted id table: streaming stimulus, a table predictor and result checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;

    localparam int TBL_DEPTH  = 32;
    localparam int QUIET_MAX  = 4000;
    localparam int TAIL_WAIT  = 150;
    localparam int POOL_SIZE  = 20;

    // Opcode 3 is not an operation; the block must answer it without touching the table.
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } table_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    entry_count;
    } table_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Operations waiting to be driven and results still owed by the block.
    table_op_t     op_queue[$];
    table_result_t expected_results[$];

    int ops_queued    = 0;
    int ops_sent      = 0;
    int ops_accepted  = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Shadow copy of the table contents.
    logic [KEY_W-1:0]    tbl_keys[TBL_DEPTH];
    logic [HANDLE_W-1:0] tbl_handles[TBL_DEPTH];
    int                  tbl_count = 0;

    sorted_id_table #(
        .MAX_ENTRIES(TBL_DEPTH),
        .KEY_BITS(KEY_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // Applies one operation to the shadow table and returns the result the block must give.
    function automatic void table_apply(input table_op_t op, output table_result_t res);
        int slot;
        int i;
        res.status       = ST_OK;
        res.found_handle = '0;
        res.position     = '0;
        slot = 0;
        // Lower bound: first entry whose key is not below the requested key.
        while (slot < tbl_count && tbl_keys[slot] < op.key) slot++;
        case (op.opcode)
            OP_INSERT: begin
                if (tbl_count >= TBL_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = tbl_count; i > slot; i--) begin
                        tbl_keys[i]    = tbl_keys[i-1];
                        tbl_handles[i] = tbl_handles[i-1];
                    end
                    tbl_keys[slot]    = op.key;
                    tbl_handles[slot] = op.handle;
                    tbl_count++;
                    res.position = POS_W'(slot);
                end
            end
            OP_DELETE, OP_LOOKUP: begin
                if (slot >= tbl_count || tbl_keys[slot] != op.key) begin
                    res.status = ST_MISSING;
                end else begin
                    res.position = POS_W'(slot);
                    if (op.opcode == OP_LOOKUP) begin
                        res.found_handle = tbl_handles[slot];
                    end else begin
                        for (i = slot; i + 1 < tbl_count; i++) begin
                            tbl_keys[i]    = tbl_keys[i+1];
                            tbl_handles[i] = tbl_handles[i+1];
                        end
                        tbl_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = POS_W'(tbl_count);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic queue_op(input logic [OPCODE_W-1:0] opcode, input logic [KEY_W-1:0] key,
                            input logic [HANDLE_W-1:0] handle);
        table_op_t item;
        item.opcode = opcode;
        item.key    = key;
        item.handle = handle;
        op_queue.push_back(item);
        ops_queued++;
    endtask

    // Random operations. Keys come mostly from a small pool so that hits and duplicates
    // are common; the mix alternates between filling and draining the table so that
    // both the full and the empty table are visited often.
    task automatic queue_random(input int n);
        logic [KEY_W-1:0]    pool[POOL_SIZE];
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key;
        int                  fill_mode;
        int                  left_in_mode;
        int                  roll;
        int                  i;
        pool[0] = '0;
        pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++) pool[i] = KEY_W'($urandom);
        fill_mode    = 1;
        left_in_mode = $urandom_range(30, 70);
        for (i = 0; i < n; i++) begin
            if (left_in_mode == 0) begin
                fill_mode    = !fill_mode;
                left_in_mode = $urandom_range(30, 70);
            end
            left_in_mode--;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                opcode = OP_NOP;
            end else if (roll < (fill_mode ? 80 : 30)) begin
                opcode = OP_INSERT;
            end else if (roll < (fill_mode ? 90 : 75)) begin
                opcode = OP_DELETE;
            end else begin
                opcode = OP_LOOKUP;
            end
            if ($urandom_range(0, 99) < 75) begin
                key = pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                key = KEY_W'($urandom);
            end
            queue_op(opcode, key, HANDLE_W'($urandom));
        end
    endtask

    // Holds until every queued operation is taken and every result has come back.
    task automatic drain_all();
        while (ops_accepted != ops_queued || expected_results.size() != 0) @(posedge aclk);
    endtask

    // Driver: presents queued operations and drives the result-side ready.
    always @(negedge aclk) begin
        table_op_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            // A new transaction may start once the current one has been taken.
            if (!s_tvalid || ops_accepted == ops_sent) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item = op_queue.pop_front();
                    s_tdata  <= S_DATA_W'({item.handle, item.key, item.opcode});
                    s_tvalid <= 1'b1;
                    ops_sent <= ops_sent + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results, predicts accepted operations and watches for a hang.
    always @(posedge aclk) begin
        table_op_t     op;
        table_result_t want;
        table_result_t got;
        if (aresetn) begin
            // Results are checked before the new operation's expectation is queued.
            if (m_tvalid && m_tready) begin
                got.status       = m_tdata[1:0];
                got.found_handle = m_tdata[6:2];
                got.position     = m_tdata[12:7];
                got.entry_count  = m_tdata[18:13];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", got.status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.found_handle != want.found_handle)
                        report_mismatch("found_handle", got.found_handle, want.found_handle);
                    if (got.position != want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.entry_count != want.entry_count)
                        report_mismatch("entry_count", got.entry_count, want.entry_count);
                end
            end
            if (s_tvalid && s_tready) begin
                op.opcode = s_tdata[1:0];
                op.key    = s_tdata[19:2];
                op.handle = s_tdata[24:20];
                table_apply(op, want);
                expected_results.push_back(want);
                ops_accepted <= ops_accepted + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_MAX) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_MAX);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        // Empty table, then duplicates, misses and removals at the key extremes.
        queue_op(OP_LOOKUP, 18'h00100, 5'd3);
        queue_op(OP_DELETE, 18'h3FFFF, 5'd0);
        queue_op(OP_NOP,    18'h2AAAA, 5'd31);
        queue_op(OP_INSERT, 18'h3FFFF, 5'd31);
        queue_op(OP_INSERT, 18'h00000, 5'd0);
        queue_op(OP_INSERT, 18'h3FFFF, 5'd5);
        queue_op(OP_LOOKUP, 18'h3FFFF, 5'd0);
        queue_op(OP_INSERT, 18'h15555, 5'd10);
        queue_op(OP_INSERT, 18'h2AAAA, 5'd21);
        queue_op(OP_LOOKUP, 18'h00000, 5'd31);
        queue_op(OP_LOOKUP, 18'h15554, 5'd0);
        queue_op(OP_LOOKUP, 18'h3FFFE, 5'd0);
        queue_op(OP_DELETE, 18'h3FFFF, 5'd0);
        queue_op(OP_LOOKUP, 18'h3FFFF, 5'd0);
        queue_op(OP_DELETE, 18'h00000, 5'd0);
        queue_op(OP_DELETE, 18'h00000, 5'd0);
        queue_op(OP_NOP,    18'h3FFFF, 5'd31);
        queue_op(OP_INSERT, 18'h00001, 5'd16);
        queue_op(OP_LOOKUP, 18'h2AAAA, 5'd0);
        queue_random(290);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles often.
        drain_all();
        send_idle_pct  = 72;
        recv_stall_pct = 0;
        queue_random(295);

        // Receiver stalls often.
        drain_all();
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        queue_random(295);

        // Both sides idle now and then.
        drain_all();
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        queue_random(295);

        drain_all();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
